// File: rtl/sxt_pkg.sv
package sxt_pkg;

    localparam int KEY_BITS   = 31;
    localparam int VAL_W      = 31;
    localparam int MAX_ITEMS  = 1024;
    localparam int POOL_NODES = 1 + KEY_BITS * MAX_ITEMS;
    localparam int ADDR_W     = $clog2(POOL_NODES);
    localparam int CNT_W      = $clog2(POOL_NODES + 1);
    localparam int LVL_W      = $clog2(KEY_BITS);

    localparam logic [VAL_W-1:0] INT_MAX = {VAL_W{1'b1}};

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             last;
    } in_word_t;

    typedef struct packed {
        logic [VAL_W-1:0] max_xor;
        logic [VAL_W-1:0] min_xor;
        logic             overflow;
        logic             is_last;
    } out_word_t;

    // index 0 = child for bit 0, index 1 = child for bit 1; 0 means no child
    typedef logic [1:0][ADDR_W-1:0] link_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        link_t             data;
    } ram_wr_t;

endpackage

// File: rtl/sxt_link_ram.sv
module sxt_link_ram (
    input  logic                      aclk,
    input  sxt_pkg::ram_wr_t          wr,
    input  logic                      rd_en,
    input  logic [sxt_pkg::ADDR_W-1:0] rd_addr,
    output sxt_pkg::link_t            rd_data
);
    import sxt_pkg::*;

    link_t link_mem [POOL_NODES];
    link_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            link_mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= link_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/sxt_step.sv
module sxt_step (
    input  sxt_pkg::link_t             links,
    input  logic                       key_bit,
    input  logic                       prefer_other,
    output logic [sxt_pkg::ADDR_W-1:0] nxt,
    output logic                       diff
);
    import sxt_pkg::*;

    logic want;
    logic taken;

    // take the preferred branch, fall back to the sibling when it is empty
    always_comb begin
        want  = key_bit ^ prefer_other;
        taken = want;
        if (links[want] == '0) begin
            taken = ~want;
        end
        nxt  = links[taken];
        diff = taken ^ key_bit;
    end

endmodule

// File: rtl/subarray_xor_max_min_trie_top.sv
// Running maximum / minimum XOR over contiguous runs of a word sequence.
//
// Input channel s_*: one word per sequence element (value, last). Result
// channel m_*: one word per input word with the running max/min subarray XOR,
// the sticky pool overflow flag and an echo of last.
//
// Each word walks a binary trie of the earlier prefix XORs three times, one
// trie level per cycle through a link memory with one read and one write
// port: a max walk, a min walk and an insert probe, followed, when the
// prefix is new, by node allocation, one node per cycle, and a result state.
// An insert that needs more nodes than the pool has free is skipped and sets
// the sticky overflow flag. One word is in flight at a time; s_ready is high
// only while the sequencer is idle.
//
// The result sits in an output register; a stalled receiver holds the block
// only when the next result is ready to be loaded. After reset, and after the
// result of a word with last set, the trie is reseeded with the zero prefix
// while s_ready stays low.
module subarray_xor_max_min_trie_top (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  sxt_pkg::in_word_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output sxt_pkg::out_word_t m_data
);
    import sxt_pkg::*;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_MAXW  = 4'd1;
    localparam logic [3:0] ST_MINW  = 4'd2;
    localparam logic [3:0] ST_FIND  = 4'd3;
    localparam logic [3:0] ST_CHECK = 4'd4;
    localparam logic [3:0] ST_ALLOC = 4'd5;
    localparam logic [3:0] ST_LEAF  = 4'd6;
    localparam logic [3:0] ST_OUT   = 4'd7;
    localparam logic [3:0] ST_SEED  = 4'd8;

    logic [3:0]        state_reg;
    logic [LVL_W-1:0]  level_reg;
    logic [ADDR_W-1:0] cur_reg;
    logic [ADDR_W-1:0] other_reg;
    logic [VAL_W-1:0]  key_reg;
    logic [VAL_W-1:0]  acc_reg;
    logic [VAL_W-1:0]  prefix_reg;
    logic [VAL_W-1:0]  best_max_reg;
    logic [VAL_W-1:0]  best_min_reg;
    logic              ovf_reg;
    logic [CNT_W-1:0]  nodes_used_reg;
    logic              last_reg;
    logic              seed_reg;
    out_word_t         out_reg;
    logic              m_valid_reg;

    ram_wr_t           ram_wr;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    link_t             rd_data;

    logic              key_bit;
    logic [ADDR_W-1:0] step_nxt;
    logic              step_diff;
    logic [VAL_W-1:0]  acc_new;
    logic [ADDR_W-1:0] find_child;
    logic [ADDR_W-1:0] find_other;
    logic [CNT_W-1:0]  needed;
    logic [CNT_W-1:0]  free_nodes;
    logic              accept;
    logic              out_load;
    logic [VAL_W-1:0]  prefix_new;

    sxt_link_ram u_ram (
        .aclk    (aclk),
        .wr      (ram_wr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    sxt_step u_step (
        .links        (rd_data),
        .key_bit      (key_bit),
        .prefer_other (state_reg == ST_MAXW),
        .nxt          (step_nxt),
        .diff         (step_diff)
    );

    assign s_ready    = (state_reg == ST_IDLE);
    assign accept     = s_valid && s_ready;
    assign out_load   = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);
    assign prefix_new = prefix_reg ^ s_data.value;

    assign key_bit    = key_reg[level_reg];
    assign acc_new    = {acc_reg[VAL_W-2:0], step_diff};
    assign find_child = rd_data[key_bit];
    assign find_other = rd_data[~key_bit];
    assign needed     = CNT_W'(level_reg) + CNT_W'(1);
    assign free_nodes = CNT_W'(POOL_NODES) - nodes_used_reg;

    // read port: root on a new word and at the end of each walk, else next node
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = '0;
        unique case (state_reg)
            ST_IDLE: begin
                rd_en = accept;
            end
            ST_MAXW, ST_MINW: begin
                rd_en   = 1'b1;
                rd_addr = (level_reg == '0) ? '0 : step_nxt;
            end
            ST_FIND: begin
                rd_en   = 1'b1;
                rd_addr = find_child;
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    // one link write per allocated level; the new node's links are written
    // on the following level, the leaf gets cleared links
    always_comb begin
        ram_wr      = '0;
        ram_wr.addr = cur_reg;
        if (state_reg == ST_ALLOC) begin
            ram_wr.en            = 1'b1;
            ram_wr.data[key_bit]  = nodes_used_reg[ADDR_W-1:0];
            ram_wr.data[~key_bit] = other_reg;
        end else if (state_reg == ST_LEAF) begin
            ram_wr.en = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_SEED;
            m_valid_reg    <= 1'b0;
            prefix_reg     <= '0;
            best_max_reg   <= '0;
            best_min_reg   <= INT_MAX;
            ovf_reg        <= 1'b0;
            seed_reg       <= 1'b0;
            nodes_used_reg <= CNT_W'(1);
        end else begin
            m_valid_reg <= out_load || (m_valid_reg && !m_ready);
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        prefix_reg <= prefix_new;
                        key_reg    <= prefix_new;
                        last_reg   <= s_data.last;
                        level_reg  <= LVL_W'(KEY_BITS - 1);
                        state_reg  <= ST_MAXW;
                    end
                end
                ST_MAXW: begin
                    acc_reg <= acc_new;
                    if (level_reg == '0) begin
                        if (acc_new > best_max_reg) begin
                            best_max_reg <= acc_new;
                        end
                        level_reg <= LVL_W'(KEY_BITS - 1);
                        state_reg <= ST_MINW;
                    end else begin
                        level_reg <= level_reg - 1'b1;
                    end
                end
                ST_MINW: begin
                    acc_reg <= acc_new;
                    if (level_reg == '0) begin
                        if (acc_new < best_min_reg) begin
                            best_min_reg <= acc_new;
                        end
                        level_reg <= LVL_W'(KEY_BITS - 1);
                        cur_reg   <= '0;
                        state_reg <= ST_FIND;
                    end else begin
                        level_reg <= level_reg - 1'b1;
                    end
                end
                ST_FIND: begin
                    if (find_child == '0) begin
                        // path ends here: level_reg + 1 nodes to add
                        other_reg <= find_other;
                        state_reg <= ST_CHECK;
                    end else begin
                        cur_reg <= find_child;
                        if (level_reg == '0) begin
                            state_reg <= ST_OUT;
                        end else begin
                            level_reg <= level_reg - 1'b1;
                        end
                    end
                end
                ST_CHECK: begin
                    if (needed > free_nodes) begin
                        ovf_reg   <= 1'b1;
                        state_reg <= ST_OUT;
                    end else begin
                        state_reg <= ST_ALLOC;
                    end
                end
                ST_ALLOC: begin
                    cur_reg        <= nodes_used_reg[ADDR_W-1:0];
                    nodes_used_reg <= nodes_used_reg + 1'b1;
                    other_reg      <= '0;
                    if (level_reg == '0) begin
                        state_reg <= ST_LEAF;
                    end else begin
                        level_reg <= level_reg - 1'b1;
                    end
                end
                ST_LEAF: begin
                    seed_reg  <= 1'b0;
                    state_reg <= seed_reg ? ST_IDLE : ST_OUT;
                end
                ST_OUT: begin
                    if (out_load) begin
                        out_reg.max_xor  <= best_max_reg;
                        out_reg.min_xor  <= best_min_reg;
                        out_reg.overflow <= ovf_reg;
                        out_reg.is_last  <= last_reg;
                        if (last_reg) begin
                            prefix_reg   <= '0;
                            best_max_reg <= '0;
                            best_min_reg <= INT_MAX;
                            ovf_reg      <= 1'b0;
                            state_reg    <= ST_SEED;
                        end else begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                ST_SEED: begin
                    // root gets a fresh link set on the first allocation
                    nodes_used_reg <= CNT_W'(1);
                    cur_reg        <= '0;
                    other_reg      <= '0;
                    key_reg        <= '0;
                    level_reg      <= LVL_W'(KEY_BITS - 1);
                    seed_reg       <= 1'b1;
                    state_reg      <= ST_ALLOC;
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    a_pool_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        nodes_used_reg <= CNT_W'(POOL_NODES))
        else $error("node count beyond pool");

    a_alloc_parent: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ALLOC) |-> (CNT_W'(cur_reg) < nodes_used_reg))
        else $error("allocation writes an unallocated parent");

    a_one_word: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready)
        else $error("second word taken while busy");

    a_reseed: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && last_reg) |=> (!s_ready && state_reg == ST_SEED))
        else $error("no reseed after last word");

endmodule
